// ===== hw/rtl/psd_pkg.sv =====
// Package with beat types, pipeline payload types and constants for the segment distance block.
`default_nettype none
package psd_pkg;

  localparam int COORD_BITS = 24;
  localparam int T_FRAC     = 16;
  localparam int T_BITS     = T_FRAC + 1;
  localparam int DIST_BITS  = 2 * COORD_BITS + 2;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int WORD_BITS  = 64;
  localparam int AXES       = 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;
  } item_beat_t;

  typedef struct packed {
    logic        [T_BITS-1:0]     param_t;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic signed [COORD_BITS-1:0] near_z;
    logic        [DIST_BITS-1:0]  dist_squared;
  } result_beat_t;

  typedef logic [AXES-1:0][COORD_BITS-1:0] coord3_t;
  typedef logic [AXES-1:0][DIFF_BITS-1:0]  diff3_t;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_t;

  typedef struct packed {
    coord3_t a;
    diff3_t  d;
    coord3_t p;
  } geo_t;

  typedef struct packed {
    geo_t                 geo;
    cls_t                 cls;
    logic [WORD_BITS-1:0] rem;
    logic [WORD_BITS-1:0] den;
    logic [T_FRAC-1:0]    quo;
  } div_beat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/psd_front.sv =====
// Front pipeline: differences, per-axis products and the dot-product sums with classification.
`default_nettype none
module psd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire psd_pkg::item_beat_t up_data,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output psd_pkg::div_beat_t       dn_data
);

  logic v1, v2, v3;
  logic r1, r2, r3;

  psd_pkg::geo_t geo1, geo2;
  psd_pkg::diff3_t w1;
  logic [psd_pkg::AXES-1:0][psd_pkg::WORD_BITS-1:0] dd2, wd2;
  psd_pkg::div_beat_t out3;

  psd_pkg::coord3_t a_in, b_in, p_in;
  psd_pkg::diff3_t  d_in, w_in;
  logic [psd_pkg::AXES-1:0][psd_pkg::WORD_BITS-1:0] dd_next, wd_next;
  logic [psd_pkg::WORD_BITS-1:0] len2, dotp;

  assign r3 = !v3 || dn_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready = r1;
  assign dn_valid = v3;
  assign dn_data  = out3;

  always_comb begin
    a_in = {up_data.start_x, up_data.start_y, up_data.start_z};
    b_in = {up_data.end_x, up_data.end_y, up_data.end_z};
    p_in = {up_data.query_x, up_data.query_y, up_data.query_z};
    for (int k = 0; k < psd_pkg::AXES; k++) begin
      d_in[k] = psd_pkg::DIFF_BITS'($signed(b_in[k])) - psd_pkg::DIFF_BITS'($signed(a_in[k]));
      w_in[k] = psd_pkg::DIFF_BITS'($signed(p_in[k])) - psd_pkg::DIFF_BITS'($signed(a_in[k]));
    end
  end

  // Products are formed at twice the width of the differences and then sign-extended to the word.
  always_comb begin
    logic signed [2*psd_pkg::DIFF_BITS-1:0] dsq, wdp;
    dsq = '0;
    wdp = '0;
    for (int k = 0; k < psd_pkg::AXES; k++) begin
      dsq = $signed(geo1.d[k]) * $signed(geo1.d[k]);
      wdp = $signed(w1[k]) * $signed(geo1.d[k]);
      dd_next[k] = psd_pkg::WORD_BITS'(dsq);
      wd_next[k] = psd_pkg::WORD_BITS'(wdp);
    end
  end

  // Sums wrap modulo the 64-bit word.
  assign len2 = dd2[0] + dd2[1] + dd2[2];
  assign dotp = wd2[0] + wd2[1] + wd2[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
    if (r1 && up_valid) begin
      geo1.a <= a_in;
      geo1.d <= d_in;
      geo1.p <= p_in;
      w1     <= w_in;
    end
    if (r2 && v1) begin
      geo2 <= geo1;
      dd2  <= dd_next;
      wd2  <= wd_next;
    end
    if (r3 && v2) begin
      out3.geo <= geo2;
      out3.rem <= dotp;
      out3.den <= len2;
      out3.quo <= '0;
      if (len2 == '0 || dotp[psd_pkg::WORD_BITS-1] || dotp == '0) begin
        out3.cls <= psd_pkg::CLS_ZERO;
      end else if (dotp >= len2) begin
        out3.cls <= psd_pkg::CLS_ONE;
      end else begin
        out3.cls <= psd_pkg::CLS_DIV;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/psd_div_stage.sv =====
// One restoring-division stage that produces one quotient bit per beat.
`default_nettype none
module psd_div_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire psd_pkg::div_beat_t up_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output psd_pkg::div_beat_t      dn_data
);

  logic v;
  psd_pkg::div_beat_t data;
  psd_pkg::div_beat_t data_next;
  logic [psd_pkg::WORD_BITS-1:0] shifted;

  assign up_ready = !v || dn_ready;
  assign dn_valid = v;
  assign dn_data  = data;

  always_comb begin
    data_next = up_data;
    shifted   = {up_data.rem[psd_pkg::WORD_BITS-2:0], 1'b0};
    if (shifted >= up_data.den) begin
      data_next.rem = shifted - up_data.den;
      data_next.quo = {up_data.quo[psd_pkg::T_FRAC-2:0], 1'b1};
    end else begin
      data_next.rem = shifted;
      data_next.quo = {up_data.quo[psd_pkg::T_FRAC-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/psd_back.sv =====
// Back pipeline: clamped parameter, closest point, error squares and the distance sum.
`default_nettype none
module psd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire psd_pkg::div_beat_t   up_data,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output psd_pkg::result_beat_t     dn_data
);

  localparam int PROD_BITS = psd_pkg::DIFF_BITS + psd_pkg::T_BITS + 1;

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  psd_pkg::geo_t geo1, geo2;
  logic [psd_pkg::T_BITS-1:0] t1, t2, t3, t4;
  logic [psd_pkg::AXES-1:0][PROD_BITS-1:0] prod2;
  psd_pkg::coord3_t near3, near4;
  logic [psd_pkg::AXES-1:0][psd_pkg::ERR_BITS-1:0] err3;
  logic [psd_pkg::AXES-1:0][psd_pkg::DIST_BITS-1:0] sq4;
  psd_pkg::result_beat_t out5;

  logic [psd_pkg::T_BITS-1:0] t_next;
  logic [psd_pkg::AXES-1:0][PROD_BITS-1:0] prod_next;
  psd_pkg::coord3_t near_next;
  logic [psd_pkg::AXES-1:0][psd_pkg::ERR_BITS-1:0] err_next;
  logic [psd_pkg::AXES-1:0][psd_pkg::DIST_BITS-1:0] sq_next;

  assign r5 = !v5 || dn_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready = r1;
  assign dn_valid = v5;
  assign dn_data  = out5;

  always_comb begin
    case (up_data.cls)
      psd_pkg::CLS_ZERO: t_next = '0;
      psd_pkg::CLS_ONE:  t_next = psd_pkg::T_BITS'(1) << psd_pkg::T_FRAC;
      psd_pkg::CLS_DIV:  t_next = {1'b0, up_data.quo};
      default:           t_next = '0;
    endcase
  end

  always_comb begin
    for (int k = 0; k < psd_pkg::AXES; k++) begin
      prod_next[k] = PROD_BITS'($signed(geo1.d[k]) * $signed({1'b0, t1}));
    end
  end

  // Offset is rounded with halves toward plus infinity, then floored to whole coordinate units.
  always_comb begin
    logic signed [PROD_BITS-1:0] rnd;
    logic signed [psd_pkg::ERR_BITS-1:0] off, n;
    rnd = '0;
    off = '0;
    n   = '0;
    for (int k = 0; k < psd_pkg::AXES; k++) begin
      rnd = $signed(prod2[k]) + $signed(PROD_BITS'(1) << (psd_pkg::T_FRAC - 1));
      off = psd_pkg::ERR_BITS'(rnd >>> psd_pkg::T_FRAC);
      n   = psd_pkg::ERR_BITS'($signed(geo2.a[k])) + off;
      near_next[k] = n[psd_pkg::COORD_BITS-1:0];
      err_next[k]  = psd_pkg::ERR_BITS'($signed(geo2.p[k])) - n;
    end
  end

  always_comb begin
    logic signed [2*psd_pkg::ERR_BITS-1:0] full;
    full = '0;
    for (int k = 0; k < psd_pkg::AXES; k++) begin
      full = $signed(err3[k]) * $signed(err3[k]);
      sq_next[k] = full[psd_pkg::DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
    if (r1 && up_valid) begin
      geo1 <= up_data.geo;
      t1   <= t_next;
    end
    if (r2 && v1) begin
      geo2  <= geo1;
      t2    <= t1;
      prod2 <= prod_next;
    end
    if (r3 && v2) begin
      t3    <= t2;
      near3 <= near_next;
      err3  <= err_next;
    end
    if (r4 && v3) begin
      t4    <= t3;
      near4 <= near3;
      sq4   <= sq_next;
    end
    if (r5 && v4) begin
      out5.param_t      <= t4;
      out5.near_x       <= near4[2];
      out5.near_y       <= near4[1];
      out5.near_z       <= near4[0];
      out5.dist_squared <= sq4[0] + sq4[1] + sq4[2];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/point_segment_closest_distance.sv =====
// Top level of the pipelined closest-point-on-segment and squared-distance block.
//
//   Channel  Handshake                   Payload
//   item     item_valid / item_ready     item   (psd_pkg::item_beat_t)
//   result   result_valid / result_ready result (psd_pkg::result_beat_t)
//
// One beat is accepted per cycle unless the result side stalls. There are three
// front stages (differences, products, sums), sixteen divider stages with one
// quotient bit each, and five back stages (clamp, offset product, rounding and
// error, squares, sum into the output register).
// Reset clears only the valid bits of the stages; payload registers are not reset.
// Each stage loads whenever it is empty or its successor moves, so bubbles
// close up under a stall and a beat is neither lost nor repeated.
`default_nettype none
module point_segment_closest_distance (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire psd_pkg::item_beat_t   item,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output psd_pkg::result_beat_t      result
);

  localparam int DIV_STAGES = psd_pkg::T_FRAC;

  logic               div_valid [DIV_STAGES+1];
  logic               div_ready [DIV_STAGES+1];
  psd_pkg::div_beat_t div_data  [DIV_STAGES+1];

  // Front end feeds the first divider stage.
  psd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (item_valid),
    .up_ready (item_ready),
    .up_data  (item),
    .dn_valid (div_valid[0]),
    .dn_ready (div_ready[0]),
    .dn_data  (div_data[0])
  );

  // The divider chain develops the quotient most significant bit first.
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    psd_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (div_valid[i]),
      .up_ready (div_ready[i]),
      .up_data  (div_data[i]),
      .dn_valid (div_valid[i+1]),
      .dn_ready (div_ready[i+1]),
      .dn_data  (div_data[i+1])
    );
  end

  // Back end clamps the parameter and forms the closest point and distance.
  psd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (div_valid[DIV_STAGES]),
    .up_ready (div_ready[DIV_STAGES]),
    .up_data  (div_data[DIV_STAGES]),
    .dn_valid (result_valid),
    .dn_ready (result_ready),
    .dn_data  (result)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_point_segment_closest_distance.sv =====
// Testbench for the closest-point-on-segment block: scoreboard, stimulus and checking.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: predicts each accepted item and checks results in order.
class segment_scoreboard;
  psd_pkg::result_beat_t pending_q[$];
  int mismatches;
  int checked;

  function new();
    mismatches = 0;
    checked = 0;
  endfunction

  // Closest point, clamped parameter and squared distance, 64-bit wrapping math.
  function psd_pkg::result_beat_t project(psd_pkg::item_beat_t it);
    logic signed [63:0] a[3], b[3], p[3], d[3], w[3];
    logic signed [63:0] len2, dotp, off, nrm, err, dist_sum;
    logic [63:0] rem, quo;
    psd_pkg::result_beat_t r;
    a[0] = it.start_x; a[1] = it.start_y; a[2] = it.start_z;
    b[0] = it.end_x;   b[1] = it.end_y;   b[2] = it.end_z;
    p[0] = it.query_x; p[1] = it.query_y; p[2] = it.query_z;
    len2 = 0;
    dotp = 0;
    dist_sum = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = b[k] - a[k];
      w[k] = p[k] - a[k];
      len2 += d[k] * d[k];
      dotp += w[k] * d[k];
    end
    if (len2 == 0 || dotp <= 0) begin
      quo = 0;
    end else if ($unsigned(dotp) >= $unsigned(len2)) begin
      quo = 64'd65536;
    end else begin
      // Restoring division, sixteen fraction bits, truncating.
      rem = dotp;
      quo = 0;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= $unsigned(len2)) begin
          rem = rem - len2;
          quo[0] = 1'b1;
        end
      end
    end
    r.param_t = quo[16:0];
    for (int k = 0; k < 3; k++) begin
      // Offset rounds half toward plus infinity.
      off = (d[k] * $signed(quo) + 64'sd32768) >>> 16;
      nrm = a[k] + off;
      err = p[k] - nrm;
      dist_sum += err * err;
      if (k == 0) r.near_x = nrm[23:0];
      if (k == 1) r.near_y = nrm[23:0];
      if (k == 2) r.near_z = nrm[23:0];
    end
    r.dist_squared = dist_sum[psd_pkg::DIST_BITS-1:0];
    return r;
  endfunction

  function void note_item(psd_pkg::item_beat_t it);
    pending_q.push_back(project(it));
  endfunction

  function void check_result(psd_pkg::result_beat_t got);
    psd_pkg::result_beat_t exp_r;
    checked++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.param_t !== exp_r.param_t || got.near_x !== exp_r.near_x ||
        got.near_y !== exp_r.near_y || got.near_z !== exp_r.near_z ||
        got.dist_squared !== exp_r.dist_squared) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch beat %0d: t %0d/%0d n %h,%h,%h / %h,%h,%h d %0d/%0d",
                 checked, exp_r.param_t, got.param_t, exp_r.near_x, exp_r.near_y,
                 exp_r.near_z, got.near_x, got.near_y, got.near_z,
                 exp_r.dist_squared, got.dist_squared);
      end
    end
  endfunction
endclass

module tb_point_segment_closest_distance;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  psd_pkg::item_beat_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  psd_pkg::result_beat_t result;

  segment_scoreboard board = new();
  int cycles = 0;
  int items_sent = 0;
  bit calm_sink = 1'b0;   // sink stops stalling while set
  int ext_sent = 0;

  point_segment_closest_distance dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always #5 clk = ~clk;

  // Every handshake is sampled at the rising edge; predictions are noted there too.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && item_valid && item_ready) board.note_item(item);
    if (!rst && result_valid && result_ready) board.check_result(result);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** point_segment_closest_distance: FAILED **");
      $finish;
    end
  end

  // The result side stalls with a probability of about 21 percent unless told to stay calm.
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= calm_sink || ($urandom_range(99) >= 21);
  end

  function automatic logic [23:0] rnd_coord(int mode);
    case (mode)
      0: return 24'($urandom());                              // anywhere
      1: return 24'($signed($urandom_range(2000)) - 1000);    // near origin
      default: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  // Present one beat and hold it until accepted, with random idle cycles before when idle is set.
  // Valid stays high after acceptance until the next idle cycle or drain clears it.
  task automatic send_item(psd_pkg::item_beat_t it, bit idle);
    if (idle) begin
      while ($urandom_range(99) < 21) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  // Directed beat from coordinate triples A, B, P.
  task automatic send_abp(int ax, int ay, int az, int bx, int by, int bz,
                          int px, int py, int pz);
    psd_pkg::item_beat_t it;
    it.start_x = 24'(ax); it.start_y = 24'(ay); it.start_z = 24'(az);
    it.end_x = 24'(bx);   it.end_y = 24'(by);   it.end_z = 24'(bz);
    it.query_x = 24'(px); it.query_y = 24'(py); it.query_z = 24'(pz);
    send_item(it, 1'b1);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    psd_pkg::item_beat_t it;
    int mode;
    int hi;
    int lo;
    hi = 8388607;
    lo = -8388608;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: zero-length segment, query behind the start, past the end,
    // interior fractions, halves in the rounding, and the coordinate extremes.
    send_abp(100, 200, 300, 100, 200, 300, 5, 6, 7);
    send_abp(0, 0, 0, 256, 0, 0, -256, 50, 0);
    send_abp(0, 0, 0, 256, 0, 0, 0, 50, 0);
    send_abp(0, 0, 0, 256, 0, 0, 256, 0, 0);
    send_abp(0, 0, 0, 256, 0, 0, 999, 1, 1);
    send_abp(0, 0, 0, 3, 0, 0, 1, 0, 0);
    send_abp(0, 0, 0, 1, 0, 0, 0, 0, 0);
    send_abp(0, 0, 0, -3, 0, 0, -1, 0, 0);
    send_abp(1, 1, 1, 3, 3, 3, 2, 2, 2);
    send_abp(lo, lo, lo, hi, hi, hi, 0, 0, 0);
    send_abp(hi, hi, hi, lo, lo, lo, lo, hi, lo);
    send_abp(lo, hi, lo, hi, lo, hi, hi, hi, hi);
    send_abp(lo, lo, lo, lo, lo, lo, hi, hi, hi);
    send_abp(hi, 0, 0, lo, 0, 0, 0, hi, lo);
    send_abp(0, 0, 0, 7, 11, 13, 5, -9, 12);
    send_abp(-1, -1, -1, 0, 0, 0, -1, -1, -1);

    // Pause the sender until every outstanding result is back.
    wait_drained();

    // Random beats: mostly small coordinates, some anywhere, some at the rails.
    // A middle stretch runs with no idling on either side.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      bit burst;
      burst = (n >= 600 && n < 800);
      calm_sink = burst;
      mode = $urandom_range(9);
      mode = (mode < 5) ? 1 : (mode < 9 ? 0 : 2);
      it.start_x = rnd_coord(mode); it.start_y = rnd_coord(mode);
      it.start_z = rnd_coord(mode);
      it.end_x = rnd_coord(mode);   it.end_y = rnd_coord(mode);
      it.end_z = rnd_coord(mode);
      it.query_x = rnd_coord(mode); it.query_y = rnd_coord(mode);
      it.query_z = rnd_coord(mode);
      // Now and then a degenerate segment.
      if ($urandom_range(19) == 0) begin
        it.end_x = it.start_x; it.end_y = it.start_y; it.end_z = it.start_z;
      end
      send_item(it, !burst);
      if (n == 1000) wait_drained();
    end
    calm_sink = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d segment queries: degenerate, clamped and interior cases,",
             items_sent);
    $display("rail coordinates and random stalls on both sides (%0d results checked)",
             board.checked);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("** point_segment_closest_distance: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending_q.size());
      $display("** point_segment_closest_distance: FAILED **");
    end
    $finish;
  end
endmodule

`default_nettype wire
